[rtl/core/prrt_pkg.sv]
package prrt_pkg;

  localparam int unsigned DefaultTableDepth = 32;
  localparam int unsigned KeyWidth = 256;
  localparam int unsigned StampWidth = 32;
  localparam int unsigned RetryWidth = 8;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned StatusWidth = 3;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_RECEIVED = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_RETRIED = 3'd5;
  localparam logic [2:0] ST_DROPPED = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRIES = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input beat, do key match
    logic insert;    // write new entry at free slot
    logic remove;    // clear matching slot
    logic scan_rd;   // read slot at scan index
    logic scan_upd;  // apply scan update at the slot last read
    logic scan_clr;  // reset scan index
  } prrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic full;
    logic scan_end;
    logic scan_timed;
    logic scan_drop;
  } prrt_stat_t;

endpackage

[rtl/core/prrt_datapath.sv]
module prrt_datapath
  import prrt_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultTableDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  prrt_cmd_t               cmd_i,
  output prrt_stat_t              stat_o,
  input  logic [KeyWidth-1:0]     parent_i,
  input  logic [KeyWidth-1:0]     child_i,
  input  logic [StampWidth-1:0]   now_i,
  input  logic [TimeoutWidth-1:0] timeout_i,
  input  logic [RetryWidth-1:0]   max_retries_i,
  output logic [KeyWidth-1:0]     scan_parent_o,
  output logic [KeyWidth-1:0]     scan_child_o,
  output logic [5:0]              count_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [TableDepth-1:0] valid_q;
  logic [KeyWidth-1:0]   parent_q [TableDepth];
  logic [KeyWidth-1:0]   child_q [TableDepth];
  logic [StampWidth-1:0] stamp_q [TableDepth];
  logic [RetryWidth-1:0] retry_q [TableDepth];
  logic [KeyWidth-1:0]   key_q, ckey_q;
  logic [StampWidth-1:0] now_q;
  logic [IdxW-1:0]       hit_idx_q, free_idx_q;
  logic                  hit_q, full_q;
  logic [CntW:0]         sidx_q;
  logic [CntW-1:0]       cnt_q;
  logic [KeyWidth-1:0]   rd_parent_q, rd_child_q;
  logic [StampWidth-1:0] rd_stamp_q;
  logic [RetryWidth-1:0] rd_retry_q;
  logic                  rd_valid_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [TableDepth-1:0] match_d;
  logic [IdxW-1:0]       hit_idx_d, free_idx_d;
  logic                  full_d;
  logic [StampWidth-1:0] age;

  always_comb begin
    hit_idx_d = '0;
    free_idx_d = '0;
    full_d = 1'b1;
    for (int s = TableDepth - 1; s >= 0; s--) begin
      match_d[s] = valid_q[s] && (parent_q[s] == parent_i);
      if (match_d[s]) begin
        hit_idx_d = IdxW'(s);
      end
      if (!valid_q[s]) begin
        free_idx_d = IdxW'(s);
        full_d = 1'b0;
      end
    end
  end

  assign age = now_q - rd_stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q <= '0;
      sidx_q <= '0;
      hit_q <= 1'b0;
      full_q <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        hit_q <= |match_d;
        full_q <= full_d;
        sidx_q <= '0;
      end
      if (cmd_i.insert) begin
        valid_q[free_idx_q] <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.remove) begin
        valid_q[hit_idx_q] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.scan_clr) begin
        sidx_q <= '0;
      end
      if (cmd_i.scan_rd) begin
        rd_valid_q <= valid_q[sidx_q[IdxW-1:0]];
        sidx_q <= sidx_q + 1'b1;
      end
      if (cmd_i.scan_upd && stat_o.scan_drop) begin
        valid_q[rd_idx_q] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= parent_i;
      ckey_q <= child_i;
      now_q <= now_i;
      hit_idx_q <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
    if (cmd_i.insert) begin
      parent_q[free_idx_q] <= key_q;
      child_q[free_idx_q] <= ckey_q;
      stamp_q[free_idx_q] <= now_q;
      retry_q[free_idx_q] <= '0;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= sidx_q[IdxW-1:0];
      rd_parent_q <= parent_q[sidx_q[IdxW-1:0]];
      rd_child_q <= child_q[sidx_q[IdxW-1:0]];
      rd_stamp_q <= stamp_q[sidx_q[IdxW-1:0]];
      rd_retry_q <= retry_q[sidx_q[IdxW-1:0]];
    end
    if (cmd_i.scan_upd && stat_o.scan_timed && !stat_o.scan_drop) begin
      stamp_q[rd_idx_q] <= now_q;
      retry_q[rd_idx_q] <= rd_retry_q + 1'b1;
    end
  end

  assign stat_o.hit = hit_q;
  assign stat_o.full = full_q;
  assign stat_o.scan_end = (sidx_q == (CntW + 1)'(TableDepth));
  assign stat_o.scan_timed = rd_valid_q && (age > StampWidth'(timeout_i));
  assign stat_o.scan_drop = stat_o.scan_timed && (rd_retry_q >= max_retries_i);
  assign scan_parent_o = rd_parent_q;
  assign scan_child_o = rd_child_q;
  assign count_o = 6'(cnt_q);

endmodule

[rtl/core/prrt_ctrl.sv]
module prrt_ctrl
  import prrt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  logic       out_free_i,
  output logic       out_load_o,
  output logic [2:0] out_status_o,
  output logic       out_keys_o,
  output logic       out_last_o,
  output prrt_cmd_t  cmd_o,
  input  prrt_stat_t stat_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    out_status_o = ST_DONE;
    out_keys_o = 1'b0;
    out_last_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_cmd_i != CMD_IGNORED) begin
          cmd_o.capture = 1'b1;
          state_d = (in_cmd_i == CMD_SCAN) ? S_READ : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
          if (op_q == CMD_RECORD) begin
            if (stat_i.hit) begin
              out_status_o = ST_DUPLICATE;
            end else if (stat_i.full) begin
              out_status_o = ST_FULL;
            end else begin
              out_status_o = ST_INSERTED;
              cmd_o.insert = 1'b1;
            end
          end else if (stat_i.hit) begin
            out_status_o = ST_REMOVED;
            cmd_o.remove = 1'b1;
          end else begin
            out_status_o = ST_ABSENT;
          end
        end
      end
      S_READ: begin
        if (stat_i.scan_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        out_last_o = 1'b0;
        out_keys_o = 1'b1;
        out_status_o = stat_i.scan_drop ? ST_DROPPED : ST_RETRIED;
        if (!stat_i.scan_timed) begin
          state_d = S_READ;
        end else if (out_free_i) begin
          out_load_o = 1'b1;
          cmd_o.scan_upd = 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= CMD_RECORD;
    end else begin
      state_q <= state_d;
      if (cmd_o.capture) begin
        op_q <= in_cmd_i;
      end
    end
  end

endmodule

[rtl/core/parent_request_retry_tracker_core.sv]
// record and received: the beat is captured in IDLE, decided in DECIDE, then held in the output register
// scan: each slot is read in READ and checked in EVAL; timed-out slots give a beat, then DONE gives the last
// a new command is accepted only in IDLE, so not before all results of the previous command are loaded
// the sequencer waits while a full output register is not taken
// reset: rst_ni asynchronous active low clears the table, timeout 30, retries 3
module parent_request_retry_tracker_core
  import prrt_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultTableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // cmd, parent_key_w0..w3, child_key_w0..w3, now_secs, zero pad
  input  logic [551:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status, out_parent_w0..w3, out_child_w0..w3, pending_count, zero pad
  output logic [527:0]  m_axis_tdata,
  output logic          m_axis_tlast,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  prrt_cmd_t             cmd;
  prrt_stat_t            stat;
  logic [TimeoutWidth-1:0] timeout_q;
  logic [RetryWidth-1:0] retries_q;
  logic                  out_load, out_keys, out_last, out_free;
  logic [2:0]            out_status;
  logic [KeyWidth-1:0]   sp, sc;
  logic [5:0]            cnt;
  logic                  ovalid_q;
  logic [527:0]          odata_q;
  logic                  olast_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd30;
      retries_q <= 8'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_RETRIES: retries_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  prrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_cmd_i(s_axis_tdata[1:0]),
    .out_free_i(out_free),
    .out_load_o(out_load),
    .out_status_o(out_status),
    .out_keys_o(out_keys),
    .out_last_o(out_last),
    .cmd_o(cmd),
    .stat_i(stat)
  );

  prrt_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .parent_i(s_axis_tdata[257:2]),
    .child_i(s_axis_tdata[513:258]),
    .now_i(s_axis_tdata[545:514]),
    .timeout_i(timeout_q),
    .max_retries_i(retries_q),
    .scan_parent_o(sp),
    .scan_child_o(sc),
    .count_o(cnt)
  );

  // pending count after this result
  logic [5:0] cnt_after;
  always_comb begin
    cnt_after = cnt;
    if (out_status == ST_INSERTED || (out_keys && out_status == ST_RETRIED)) begin
      cnt_after = (out_status == ST_INSERTED) ? cnt + 6'd1 : cnt;
    end
    if (out_status == ST_REMOVED || out_status == ST_DROPPED) begin
      cnt_after = cnt - 6'd1;
    end
  end

  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_free) begin
      ovalid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      odata_q <= {7'd0, cnt_after, sc & {KeyWidth{out_keys}}, sp & {KeyWidth{out_keys}},
                  out_status};
      olast_q <= out_last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tlast = olast_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !cmd.remove && !cmd.scan_upd) else $error("insert overlaps");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> !s_axis_tready) else $error("ready during scan");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result overwritten");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import prrt_pkg::*;

  localparam int unsigned Depth = DefaultTableDepth;
  localparam int unsigned DrainCycles = 2 * Depth + 10;
  localparam int unsigned WatchdogLimit = 5000;

  typedef struct packed {
    logic [2:0]   status;
    logic [255:0] parent;
    logic [255:0] child;
    logic [5:0]   pending;
    logic         last;
  } tracker_result_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [255:0] pkey;
    logic [255:0] ckey;
    logic [31:0]  now;
    bit           typed;
    logic [2:0]   status;
    logic [5:0]   pending;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [551:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [527:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  parent_request_retry_tracker_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // tracker model state
  bit           slot_live[Depth];
  logic [255:0] slot_parent[Depth];
  logic [255:0] slot_child[Depth];
  logic [31:0]  slot_stamp[Depth];
  logic [7:0]   slot_retries[Depth];
  logic [15:0]  timeout_secs;
  logic [7:0]   max_retries;

  tracker_result_t results_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned retried_seen = 0;
  int unsigned dropped_seen = 0;
  int unsigned full_seen = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void add_result(input tracker_result_t r);
    results_due = {results_due, r};
  endfunction

  function automatic logic [5:0] live_count();
    logic [5:0] n;
    n = '0;
    for (int s = 0; s < Depth; s++) if (slot_live[s]) n++;
    return n;
  endfunction

  function automatic int find_parent(input logic [255:0] key);
    for (int s = 0; s < Depth; s++) if (slot_live[s] && slot_parent[s] == key) return s;
    return -1;
  endfunction

  function automatic tracker_result_t make_result(input logic [2:0] st, input int slot,
                                                  input bit is_last);
    tracker_result_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.parent = slot_parent[slot];
      r.child = slot_child[slot];
    end
    r.pending = live_count();
    r.last = is_last;
    return r;
  endfunction

  task automatic track_command(input logic [1:0] cmd, input logic [255:0] pkey,
                               input logic [255:0] ckey, input logic [31:0] now);
    int s;
    logic [31:0] age;
    case (cmd)
      CMD_RECORD: begin
        if (find_parent(pkey) >= 0) begin
          add_result(make_result(ST_DUPLICATE, -1, 1));
        end else begin
          s = -1;
          for (int i = Depth - 1; i >= 0; i--) if (!slot_live[i]) s = i;
          if (s < 0) begin
            add_result(make_result(ST_FULL, -1, 1));
          end else begin
            slot_parent[s] = pkey;
            slot_child[s] = ckey;
            slot_stamp[s] = now;
            slot_retries[s] = '0;
            slot_live[s] = 1;
            add_result(make_result(ST_INSERTED, -1, 1));
          end
        end
      end
      CMD_RECEIVED: begin
        s = find_parent(pkey);
        if (s < 0) begin
          add_result(make_result(ST_ABSENT, -1, 1));
        end else begin
          slot_live[s] = 0;
          add_result(make_result(ST_REMOVED, -1, 1));
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < Depth; i++) begin
          if (slot_live[i]) begin
            age = now - slot_stamp[i];
            if (age > {16'd0, timeout_secs}) begin
              if (slot_retries[i] >= max_retries) begin
                slot_live[i] = 0;
                add_result(make_result(ST_DROPPED, i, 0));
              end else begin
                slot_retries[i] = slot_retries[i] + 8'd1;
                slot_stamp[i] = now;
                add_result(make_result(ST_RETRIED, i, 0));
              end
            end
          end
        end
        add_result(make_result(ST_DONE, -1, 1));
      end
      default: ;
    endcase
  endtask

  // sender: called right after a rising edge, returns at the accepting edge
  task automatic send_command(input logic [1:0] cmd, input logic [255:0] pkey,
                              input logic [255:0] ckey, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, now, ckey, pkey, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_in++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_secs = data;
    else max_retries = data[7:0];
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    tracker_result_t got, want;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      got.status = m_axis_tdata[2:0];
      got.parent = m_axis_tdata[258:3];
      got.child = m_axis_tdata[514:259];
      got.pending = m_axis_tdata[520:515];
      got.last = m_axis_tlast;
      if (got.status == ST_RETRIED) retried_seen++;
      if (got.status == ST_DROPPED) dropped_seen++;
      if (got.status == ST_FULL) full_seen++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d", got.status));
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
        if (got.parent !== want.parent)
          report_mismatch($sformatf("parent %h want %h", got.parent, want.parent));
        if (got.child !== want.child)
          report_mismatch($sformatf("child %h want %h", got.child, want.child));
        if (got.pending !== want.pending)
          report_mismatch($sformatf("pending %0d want %0d", got.pending, want.pending));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", results_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    tracker_result_t typed_res;
    logic [255:0] key_pool[48];
    logic [255:0] pk;
    logic [255:0] ck;
    logic [1:0] cmd;
    logic [31:0] clock_secs;
    int unsigned pick;
    logic [15:0] phase_timeout[6] = '{16'd0, 16'hFFFF, 16'd5, 16'd20, 16'd0, 16'd0};
    logic [7:0] phase_retries[6] = '{8'd0, 8'hFF, 8'd1, 8'd3, 8'd0, 8'd0};

    timeout_secs = 16'd30;
    max_retries = 8'd3;
    for (int s = 0; s < Depth; s++) slot_live[s] = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cmd, parent, child, now, typed, status, pending
    rows = '{
      '{CMD_SCAN, '0, '0, 32'd0, 1, ST_DONE, 6'd0},
      '{CMD_RECEIVED, '1, '0, 32'd0, 1, ST_ABSENT, 6'd0},
      '{CMD_RECORD, '1, '1, 32'd0, 1, ST_INSERTED, 6'd1},
      '{CMD_RECORD, '1, '0, 32'd7, 1, ST_DUPLICATE, 6'd1},
      '{CMD_RECORD, '0, '0, 32'd100, 1, ST_INSERTED, 6'd2},
      '{CMD_IGNORED, '1, '1, 32'hFFFF_FFFF, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd30, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd31, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd31, 1, ST_DONE, 6'd2},
      '{CMD_SCAN, '0, '0, 32'hFFFF_FFFF, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd40, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd200, 0, ST_DONE, 6'd0},
      '{CMD_SCAN, '0, '0, 32'd400, 0, ST_DONE, 6'd0},
      '{CMD_RECEIVED, '0, '0, 32'd0, 0, ST_DONE, 6'd0},
      '{CMD_RECEIVED, '1, '0, 32'd0, 0, ST_DONE, 6'd0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_command(row.cmd, row.pkey, row.ckey, row.now);
      if (row.typed) begin
        typed_res = '0;
        typed_res.status = row.status;
        typed_res.pending = row.pending;
        typed_res.last = 1'b1;
        track_command(row.cmd, row.pkey, row.ckey, row.now);
        void'(results_due.pop_back());
        add_result(typed_res);
      end else begin
        track_command(row.cmd, row.pkey, row.ckey, row.now);
      end
    end

    foreach (key_pool[i]) key_pool[i] = rand_key();
    key_pool[0] = '1;
    key_pool[1] = '0;
    clock_secs = 32'd1000;

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      send_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 71 : 0;
      recv_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 34 : 0;
      write_reg(CFG_TIMEOUT, (phase >= 4) ? 16'($urandom_range(0, 60)) : phase_timeout[phase]);
      write_reg(CFG_RETRIES, {8'($urandom),
                              (phase >= 4) ? 8'($urandom_range(0, 4)) : phase_retries[phase]});
      @(posedge clk_i);
      for (int n = 0; n < 48; n++) begin
        if (n == 24 && phase == 1) wait_drained();
        pick = $urandom_range(99);
        cmd = (pick < 45) ? CMD_RECORD : (pick < 70) ? CMD_RECEIVED :
              (pick < 95) ? CMD_SCAN : CMD_IGNORED;
        pk = ($urandom_range(99) < 85) ? key_pool[$urandom_range(47)] : rand_key();
        ck = rand_key();
        if ($urandom_range(99) < 5) clock_secs = $urandom;
        else clock_secs = clock_secs + $urandom_range(0, 40);
        send_command(cmd, pk, ck, clock_secs);
        track_command(cmd, pk, ck, clock_secs);
      end
    end
    wait_drained();

    $display("%0d commands in, %0d results out: %0d retried, %0d dropped, %0d table-full",
             beats_in, beats_out, retried_seen, dropped_seen, full_seen);
    $display("six register settings under three sender/receiver stall mixes");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
